FILE: hw/rtl/lrsp_pkg.sv
`default_nettype none
package lrsp_pkg;

    localparam int NUM_STATES_DEF       = 256;
    localparam int NUM_TERMINALS_DEF    = 64;
    localparam int NUM_NONTERMINALS_DEF = 64;
    localparam int NUM_RULES_DEF        = 256;
    localparam int STACK_DEPTH_DEF      = 256;
    localparam int MAX_REDUCE_CHAIN_DEF = 62;

    localparam int SKIP_TYPE = 33;

    typedef enum logic [2:0] {
        OP_WR_ACTION = 3'd0,
        OP_WR_GOTO   = 3'd1,
        OP_WR_RULE   = 3'd2,
        OP_TOKEN     = 3'd3,
        OP_RESTART   = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        EV_WRITTEN  = 4'd0,
        EV_SHIFT    = 4'd1,
        EV_REDUCE   = 4'd2,
        EV_ACCEPT   = 4'd3,
        EV_SKIP     = 4'd4,
        EV_SYNTAX   = 4'd5,
        EV_INVALID  = 4'd6,
        EV_OVERFLOW = 4'd7,
        EV_HALTED   = 4'd8
    } ev_t;

    typedef enum logic [1:0] {
        ACT_EMPTY  = 2'd0,
        ACT_SHIFT  = 2'd1,
        ACT_REDUCE = 2'd2,
        ACT_ACCEPT = 2'd3
    } act_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACT  = 5'b00010,
        S_RULE = 5'b00100,
        S_STK  = 5'b01000,
        S_GOTO = 5'b10000
    } fsm_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lrsp_if.sv
`default_nettype none
interface lrsp_item_if;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic [7:0]        row;
    logic [5:0]        column;
    logic [1:0]        entry_kind;
    logic [7:0]        entry_value;
    logic [4:0]        rule_length;
    logic signed [6:0] token_type;

    modport source (output valid, operation, row, column, entry_kind, entry_value,
                    rule_length, token_type, input ready);
    modport sink (input valid, operation, row, column, entry_kind, entry_value,
                  rule_length, token_type, output ready);
endinterface

interface lrsp_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] rule_number;
    logic [7:0] new_state;
    logic       last;

    modport source (output valid, event_res, rule_number, new_state, last, input ready);
    modport sink (input valid, event_res, rule_number, new_state, last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lrsp_ram.sv
`default_nettype none
module lrsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/lr_shift_reduce_parser.sv
`default_nettype none
// LR shift-reduce parser driven by action, goto and rule tables held in on-chip RAM.
// Table writes and restart answer with one written event. A token reads its action
// entry, then shifts or ends; each reduction before that reads the rule, stack and
// goto tables in turn and then the next action entry, a chain of dependent RAM reads.
// Only one request is in flight at a time; results leave through an output register.
module lr_shift_reduce_parser #(
    parameter int NUM_STATES       = lrsp_pkg::NUM_STATES_DEF,
    parameter int NUM_TERMINALS    = lrsp_pkg::NUM_TERMINALS_DEF,
    parameter int NUM_NONTERMINALS = lrsp_pkg::NUM_NONTERMINALS_DEF,
    parameter int NUM_RULES        = lrsp_pkg::NUM_RULES_DEF,
    parameter int STACK_DEPTH      = lrsp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_REDUCE_CHAIN = lrsp_pkg::MAX_REDUCE_CHAIN_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    lrsp_item_if.sink    item,
    lrsp_result_if.source result
);
    import lrsp_pkg::*;

    localparam int ADEPTH = NUM_STATES * NUM_TERMINALS;
    localparam int GDEPTH = NUM_STATES * NUM_NONTERMINALS;
    localparam int AAW    = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
    localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int RAW    = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int SAW    = $clog2(STACK_DEPTH);
    localparam int SPW    = $clog2(STACK_DEPTH + 1);
    localparam int CW     = $clog2(MAX_REDUCE_CHAIN + 1);

    fsm_t              state_reg, state_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [7:0]        top_reg, top_next;
    logic              halted_reg, halted_next;
    logic [7:0]        tidx_reg, tidx_next;
    logic              skip_reg, skip_next;
    logic [CW-1:0]     red_reg, red_next;
    logic [7:0]        rule_reg, rule_next;
    logic [4:0]        len_reg, len_next;
    logic [5:0]        lhs_reg, lhs_next;
    logic              idx0_reg, idx0_next;
    logic              aok_reg, aok_next;
    logic              gok_reg, gok_next;

    logic              ov_reg, ov_next;
    logic [3:0]        ev_reg, ev_next;
    logic [7:0]        rn_reg, rn_next;
    logic [7:0]        ns_reg, ns_next;
    logic              last_reg, last_next;

    logic              act_we, act_re, goto_we, goto_re, rule_we, rule_re, stk_we, stk_re;
    logic [AAW-1:0]    act_waddr, act_raddr;
    logic [GAW-1:0]    goto_waddr, goto_raddr;
    logic [RAW-1:0]    rule_waddr, rule_raddr;
    logic [SAW-1:0]    stk_waddr, stk_raddr;
    logic [9:0]        act_wdata, act_rdata;
    logic [8:0]        goto_wdata, goto_rdata;
    logic [10:0]       rule_wdata, rule_rdata;
    logic [7:0]        stk_wdata, stk_rdata;

    logic              slot_free;
    logic              accept_in;
    logic [1:0]        kind;
    logic [7:0]        aval;
    logic [7:0]        stk_top;
    logic [7:0]        gstate;
    int                newcount;

    lrsp_ram #(.WIDTH(10), .DEPTH(ADEPTH)) u_action (
        .clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
        .re(act_re), .raddr(act_raddr), .rdata(act_rdata));
    lrsp_ram #(.WIDTH(9), .DEPTH(GDEPTH)) u_goto (
        .clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
        .re(goto_re), .raddr(goto_raddr), .rdata(goto_rdata));
    lrsp_ram #(.WIDTH(11), .DEPTH(NUM_RULES)) u_rule (
        .clk(clk), .we(rule_we), .waddr(rule_waddr), .wdata(rule_wdata),
        .re(rule_re), .raddr(rule_raddr), .rdata(rule_rdata));
    lrsp_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata));

    assign slot_free   = !ov_reg || result.ready;
    assign item.ready  = (state_reg == S_IDLE) && slot_free;
    assign accept_in   = item.valid && item.ready;

    assign result.valid       = ov_reg;
    assign result.event_res   = ev_reg;
    assign result.rule_number = rn_reg;
    assign result.new_state   = ns_reg;
    assign result.last        = last_reg;

    assign kind    = aok_reg ? act_rdata[9:8] : ACT_EMPTY;
    assign aval    = act_rdata[7:0];
    // entry 0 is never written; it reads as state zero
    assign stk_top = idx0_reg ? 8'd0 : stk_rdata;
    assign gstate  = goto_rdata[7:0];

    always_comb
    begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        top_next    = top_reg;
        halted_next = halted_reg;
        tidx_next   = tidx_reg;
        skip_next   = skip_reg;
        red_next    = red_reg;
        rule_next   = rule_reg;
        len_next    = len_reg;
        lhs_next    = lhs_reg;
        idx0_next   = idx0_reg;
        aok_next    = aok_reg;
        gok_next    = gok_reg;
        ov_next     = ov_reg && !result.ready;
        ev_next     = ev_reg;
        rn_next     = rn_reg;
        ns_next     = ns_reg;
        last_next   = last_reg;

        act_we     = 1'b0;
        act_waddr  = AAW'(int'(item.row) * NUM_TERMINALS + int'(item.column));
        act_wdata  = {item.entry_kind, item.entry_value};
        act_re     = 1'b0;
        act_raddr  = AAW'(int'(top_reg) * NUM_TERMINALS + int'(tidx_reg));
        goto_we    = 1'b0;
        goto_waddr = GAW'(int'(item.row) * NUM_NONTERMINALS + int'(item.column));
        goto_wdata = {(item.entry_kind != 2'd0), item.entry_value};
        goto_re    = 1'b0;
        goto_raddr = GAW'(int'(stk_top) * NUM_NONTERMINALS + int'(lhs_reg));
        rule_we    = 1'b0;
        rule_waddr = RAW'(item.row);
        rule_wdata = {item.rule_length, item.column};
        rule_re    = 1'b0;
        rule_raddr = RAW'(aval);
        stk_we     = 1'b0;
        stk_waddr  = SAW'(sp_reg);
        stk_wdata  = aval;
        stk_re     = 1'b0;
        stk_raddr  = SAW'(int'(sp_reg) - int'(rule_rdata[10:6]) - 1);
        newcount   = int'(sp_reg) - int'(len_reg) + 1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    ov_next   = 1'b1;
                    ev_next   = EV_WRITTEN;
                    rn_next   = 8'd0;
                    ns_next   = 8'd0;
                    last_next = 1'b1;
                    case (item.operation)
                        OP_WR_ACTION:
                            act_we = (int'(item.row) < NUM_STATES) &&
                                     (int'(item.column) < NUM_TERMINALS);
                        OP_WR_GOTO:
                            goto_we = (int'(item.row) < NUM_STATES) &&
                                      (int'(item.column) < NUM_NONTERMINALS);
                        OP_WR_RULE:
                            rule_we = (int'(item.row) < NUM_RULES);
                        OP_RESTART:
                        begin
                            sp_next     = SPW'(1);
                            top_next    = 8'd0;
                            halted_next = 1'b0;
                        end
                        OP_TOKEN:
                        begin
                            if (halted_reg)
                            begin
                                ev_next = EV_HALTED;
                            end
                            else if (item.token_type < 7'sd1 ||
                                     int'(item.token_type) > NUM_TERMINALS)
                            begin
                                ev_next     = EV_INVALID;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                ov_next   = 1'b0;
                                tidx_next = 8'(item.token_type - 7'sd1);
                                skip_next = (int'(item.token_type) == SKIP_TYPE);
                                red_next  = '0;
                                act_re    = 1'b1;
                                act_raddr = AAW'(int'(top_reg) * NUM_TERMINALS +
                                                 int'(item.token_type) - 1);
                                aok_next  = (int'(top_reg) < NUM_STATES);
                                state_next = S_ACT;
                            end
                        end
                        default:
                            ov_next = 1'b0;
                    endcase
                end
            end
            S_ACT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    rn_next    = 8'd0;
                    ns_next    = 8'd0;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                    case (kind)
                        ACT_EMPTY:
                        begin
                            ev_next     = skip_reg ? EV_SKIP : EV_SYNTAX;
                            halted_next = !skip_reg;
                        end
                        ACT_ACCEPT:
                        begin
                            ev_next     = EV_ACCEPT;
                            halted_next = 1'b1;
                        end
                        ACT_SHIFT:
                        begin
                            if (int'(sp_reg) >= STACK_DEPTH)
                            begin
                                ev_next     = EV_OVERFLOW;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                stk_we   = 1'b1;
                                sp_next  = sp_reg + SPW'(1);
                                top_next = aval;
                                ev_next  = EV_SHIFT;
                                ns_next  = aval;
                            end
                        end
                        default:
                        begin
                            if (int'(red_reg) >= MAX_REDUCE_CHAIN)
                            begin
                                ev_next     = EV_OVERFLOW;
                                halted_next = 1'b1;
                            end
                            else if (int'(aval) >= NUM_RULES)
                            begin
                                ev_next     = EV_SYNTAX;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                ov_next    = ov_reg && !result.ready;
                                rule_re    = 1'b1;
                                rule_next  = aval;
                                state_next = S_RULE;
                            end
                        end
                    endcase
                end
            end
            S_RULE:
            begin
                if (int'(rule_rdata[10:6]) >= int'(sp_reg))
                begin
                    // underflow: needs the output slot
                    if (slot_free)
                    begin
                        ov_next     = 1'b1;
                        ev_next     = EV_SYNTAX;
                        rn_next     = 8'd0;
                        ns_next     = 8'd0;
                        last_next   = 1'b1;
                        halted_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    stk_re     = 1'b1;
                    len_next   = rule_rdata[10:6];
                    lhs_next   = rule_rdata[5:0];
                    idx0_next  = (int'(sp_reg) - int'(rule_rdata[10:6]) - 1) == 0;
                    state_next = S_STK;
                end
            end
            S_STK:
            begin
                goto_re    = 1'b1;
                gok_next   = (int'(stk_top) < NUM_STATES) &&
                             (int'(lhs_reg) < NUM_NONTERMINALS);
                state_next = S_GOTO;
            end
            S_GOTO:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    rn_next = 8'd0;
                    ns_next = 8'd0;
                    if (!(gok_reg && goto_rdata[8]))
                    begin
                        ev_next     = EV_SYNTAX;
                        last_next   = 1'b1;
                        halted_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (newcount > STACK_DEPTH)
                    begin
                        ev_next     = EV_OVERFLOW;
                        last_next   = 1'b1;
                        halted_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        stk_we     = 1'b1;
                        stk_waddr  = SAW'(newcount - 1);
                        stk_wdata  = gstate;
                        sp_next    = SPW'(newcount);
                        top_next   = gstate;
                        ev_next    = EV_REDUCE;
                        rn_next    = rule_reg;
                        ns_next    = gstate;
                        last_next  = 1'b0;
                        red_next   = red_reg + CW'(1);
                        act_re     = 1'b1;
                        act_raddr  = AAW'(int'(gstate) * NUM_TERMINALS + int'(tidx_reg));
                        aok_next   = (int'(gstate) < NUM_STATES);
                        state_next = S_ACT;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sp_reg     <= SPW'(1);
            top_reg    <= 8'd0;
            halted_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            top_reg    <= top_next;
            halted_reg <= halted_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tidx_reg <= tidx_next;
        skip_reg <= skip_next;
        red_reg  <= red_next;
        rule_reg <= rule_next;
        len_reg  <= len_next;
        lhs_reg  <= lhs_next;
        idx0_reg <= idx0_next;
        aok_reg  <= aok_next;
        gok_reg  <= gok_next;
        ev_reg   <= ev_next;
        rn_reg   <= rn_next;
        ns_reg   <= ns_next;
        last_reg <= last_next;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/lrsp_checker.sv
`default_nettype none
module lrsp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [3:0] event_res,
    input wire logic [7:0] rule_number,
    input wire logic [7:0] new_state,
    input wire logic       last
);
    import lrsp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_notlast: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> event_res == EV_REDUCE)
        else $error("only reduce events may be non-final");

    a_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res != EV_SHIFT && event_res != EV_REDUCE |-> new_state == 8'd0)
        else $error("new_state set on a non-push event");

    a_rule: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res != EV_REDUCE |-> rule_number == 8'd0)
        else $error("rule_number set outside reduce");
endmodule

bind lr_shift_reduce_parser lrsp_checker u_lrsp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .res_valid(result.valid),
    .res_ready(result.ready),
    .event_res(result.event_res),
    .rule_number(result.rule_number),
    .new_state(result.new_state),
    .last(result.last)
);
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lrsp_pkg::*;

    localparam int NT   = NUM_TERMINALS_DEF;
    localparam int NNT  = NUM_NONTERMINALS_DEF;
    localparam int NST  = NUM_STATES_DEF;
    localparam int SDEP = STACK_DEPTH_DEF;

    // need codes from the parse predictor: table entry not yet written
    localparam int NEED_NONE   = 0;
    localparam int NEED_ACTION = 1;
    localparam int NEED_RULE   = 2;
    localparam int NEED_GOTO   = 3;

    // model copies: 0 shadows the generator, 1 tracks accepted requests
    localparam int GEN = 0;
    localparam int CHK = 1;

    // operation codes with no meaning, answered by nothing
    localparam logic [2:0] OP_BAD_FIRST = 3'd5;
    localparam logic [2:0] OP_BAD_LAST  = 3'd7;

    typedef struct packed {
        logic              hold;
        logic [2:0]        operation;
        logic [7:0]        row;
        logic [5:0]        column;
        logic [1:0]        entry_kind;
        logic [7:0]        entry_value;
        logic [4:0]        rule_length;
        logic signed [6:0] token_type;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    typedef struct packed {
        ev_t        ev;
        logic [7:0] rule_number;
        logic [7:0] new_state;
        logic       last;
    } parse_ev_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lrsp_item_if   item_ch();
    lrsp_result_if res_ch();

    lr_shift_reduce_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    always #5 clk = ~clk;

    logic [9:0] act_mem  [2][NST*NT];
    bit         act_set  [2][NST*NT];
    logic [8:0] goto_mem [2][NST*NNT];
    bit         goto_set [2][NST*NNT];
    logic [10:0] rule_mem [2][256];
    bit         rule_set [2][256];
    logic [7:0] stk      [2][SDEP];
    int         sp       [2];
    bit         halt     [2];

    req_t      pending[$];
    parse_ev_t expected_events[$];
    int        errors = 0;
    bit        quiet = 1'b0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic parse_ev_t mk_ev(ev_t e, int rn, int ns, bit l);
        parse_ev_t p;
        p.ev = e;
        p.rule_number = rn[7:0];
        p.new_state = ns[7:0];
        p.last = l;
        return p;
    endfunction

    function automatic void queue_ev(ref parse_ev_t evq[$], input ev_t e, input int rn,
                                     input int ns, input bit l);
        evq.insert(evq.size(), mk_ev(e, rn, ns, l));
    endfunction

    task automatic queue_req(input req_t r);
        pending.insert(pending.size(), r);
    endtask

    function automatic void parse_step(input int m, input req_t r, ref parse_ev_t evq[$],
                                       output int need, output int nrow, output int ncol);
        int ty, st, idx, n, top, gidx, len, lhs, newcount;
        logic [1:0] kind;
        logic [7:0] val;
        logic [8:0] g;
        need = NEED_NONE;
        nrow = 0;
        ncol = 0;
        case (r.operation)
            OP_WR_ACTION:
            begin
                idx = r.row * NT + r.column;
                act_mem[m][idx] = {r.entry_kind, r.entry_value};
                act_set[m][idx] = 1'b1;
                queue_ev(evq, EV_WRITTEN, 0, 0, 1'b1);
            end
            OP_WR_GOTO:
            begin
                idx = r.row * NNT + r.column;
                goto_mem[m][idx] = {r.entry_kind != 2'd0, r.entry_value};
                goto_set[m][idx] = 1'b1;
                queue_ev(evq, EV_WRITTEN, 0, 0, 1'b1);
            end
            OP_WR_RULE:
            begin
                rule_mem[m][r.row] = {r.rule_length, r.column};
                rule_set[m][r.row] = 1'b1;
                queue_ev(evq, EV_WRITTEN, 0, 0, 1'b1);
            end
            OP_RESTART:
            begin
                sp[m] = 1;
                stk[m][0] = 8'd0;
                halt[m] = 1'b0;
                queue_ev(evq, EV_WRITTEN, 0, 0, 1'b1);
            end
            OP_TOKEN:
            begin
                ty = int'(r.token_type);
                n = 0;
                if (halt[m])
                begin
                    queue_ev(evq, EV_HALTED, 0, 0, 1'b1);
                    return;
                end
                if (ty < 1 || ty > NT)
                begin
                    halt[m] = 1'b1;
                    queue_ev(evq, EV_INVALID, 0, 0, 1'b1);
                    return;
                end
                forever
                begin
                    st = stk[m][sp[m]-1];
                    idx = st * NT + ty - 1;
                    if (!act_set[m][idx])
                    begin
                        need = NEED_ACTION;
                        nrow = st;
                        ncol = ty - 1;
                        return;
                    end
                    {kind, val} = act_mem[m][idx];
                    case (kind)
                        ACT_EMPTY:
                        begin
                            if (ty == SKIP_TYPE)
                                queue_ev(evq, EV_SKIP, 0, 0, 1'b1);
                            else
                            begin
                                halt[m] = 1'b1;
                                queue_ev(evq, EV_SYNTAX, 0, 0, 1'b1);
                            end
                            return;
                        end
                        ACT_ACCEPT:
                        begin
                            halt[m] = 1'b1;
                            queue_ev(evq, EV_ACCEPT, 0, 0, 1'b1);
                            return;
                        end
                        ACT_SHIFT:
                        begin
                            if (sp[m] >= SDEP)
                            begin
                                halt[m] = 1'b1;
                                queue_ev(evq, EV_OVERFLOW, 0, 0, 1'b1);
                                return;
                            end
                            stk[m][sp[m]] = val;
                            sp[m]++;
                            queue_ev(evq, EV_SHIFT, 0, val, 1'b1);
                            return;
                        end
                        default:
                        begin
                            if (n >= MAX_REDUCE_CHAIN_DEF)
                            begin
                                halt[m] = 1'b1;
                                queue_ev(evq, EV_OVERFLOW, 0, 0, 1'b1);
                                return;
                            end
                            if (!rule_set[m][val])
                            begin
                                need = NEED_RULE;
                                nrow = val;
                                return;
                            end
                            len = rule_mem[m][val][10:6];
                            lhs = rule_mem[m][val][5:0];
                            if (len >= sp[m])
                            begin
                                halt[m] = 1'b1;
                                queue_ev(evq, EV_SYNTAX, 0, 0, 1'b1);
                                return;
                            end
                            top = stk[m][sp[m]-len-1];
                            gidx = top * NNT + lhs;
                            if (!goto_set[m][gidx])
                            begin
                                need = NEED_GOTO;
                                nrow = top;
                                ncol = lhs;
                                return;
                            end
                            g = goto_mem[m][gidx];
                            if (!g[8])
                            begin
                                halt[m] = 1'b1;
                                queue_ev(evq, EV_SYNTAX, 0, 0, 1'b1);
                                return;
                            end
                            newcount = sp[m] - len + 1;
                            if (newcount > SDEP)
                            begin
                                halt[m] = 1'b1;
                                queue_ev(evq, EV_OVERFLOW, 0, 0, 1'b1);
                                return;
                            end
                            stk[m][newcount-1] = g[7:0];
                            sp[m] = newcount;
                            queue_ev(evq, EV_REDUCE, val, g[7:0], 1'b0);
                            n++;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    endfunction

    // unused fields carry noise so every bit toggles
    function automatic req_t noise_req(logic [2:0] op);
        req_t r;
        r = req_t'(REQ_W'({$urandom, $urandom}));
        r.hold = 1'b0;
        r.operation = op;
        return r;
    endfunction

    task automatic add_req(input req_t r);
        parse_ev_t dump[$];
        int nd, nr, nc;
        queue_req(r);
        parse_step(GEN, r, dump, nd, nr, nc);
    endtask

    task automatic add_hold();
        req_t r;
        r = '0;
        r.hold = 1'b1;
        queue_req(r);
    endtask

    task automatic add_write(input op_t op, input int rw, input int col, input int kind,
                             input int val, input int len);
        req_t r;
        r = noise_req(op);
        r.row = rw[7:0];
        r.column = col[5:0];
        r.entry_kind = kind[1:0];
        r.entry_value = val[7:0];
        r.rule_length = len[4:0];
        add_req(r);
    endtask

    function automatic int pick_small(int lim, int full);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, full) : $urandom_range(0, lim);
    endfunction

    // fills whatever table entry the token walks into before it is sent
    task automatic add_token(input int ty);
        req_t r;
        parse_ev_t dump[$];
        logic [7:0] saved_stk[SDEP];
        int saved_sp, nd, nr, nc, pct;
        bit saved_halt;
        r = noise_req(OP_TOKEN);
        r.token_type = ty[6:0];
        forever
        begin
            saved_stk = stk[GEN];
            saved_sp = sp[GEN];
            saved_halt = halt[GEN];
            dump.delete();
            parse_step(GEN, r, dump, nd, nr, nc);
            if (nd == NEED_NONE)
                break;
            stk[GEN] = saved_stk;
            sp[GEN] = saved_sp;
            halt[GEN] = saved_halt;
            pct = $urandom_range(0, 99);
            case (nd)
                NEED_ACTION:
                    if (pct < 45)
                        add_write(OP_WR_ACTION, nr, nc, ACT_SHIFT, pick_small(15, 255), 0);
                    else if (pct < 75)
                        add_write(OP_WR_ACTION, nr, nc, ACT_REDUCE, pick_small(15, 255), 0);
                    else if (pct < 83)
                        add_write(OP_WR_ACTION, nr, nc, ACT_ACCEPT, $urandom_range(0, 255), 0);
                    else
                        add_write(OP_WR_ACTION, nr, nc, ACT_EMPTY, $urandom_range(0, 255), 0);
                NEED_RULE:
                    add_write(OP_WR_RULE, nr, pick_small(7, 63), 0, 0, pick_small(3, 31));
                default:
                    add_write(OP_WR_GOTO, nr, nc, $urandom_range(0, 3), pick_small(15, 255), 0);
            endcase
        end
        queue_req(r);
    endtask

    function automatic int rand_type();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return $urandom_range(1, 8);
        if (p < 78) return SKIP_TYPE;
        if (p < 85) return $urandom_range(9, 63);
        if (p < 93) return ($urandom_range(0, 1) == 0) ? 0 : -int'($urandom_range(1, 64));
        return 64;
    endfunction

    initial
    begin
        int k;
        item_ch.valid = 1'b0;
        item_ch.operation = '0;
        item_ch.row = '0;
        item_ch.column = '0;
        item_ch.entry_kind = '0;
        item_ch.entry_value = '0;
        item_ch.rule_length = '0;
        item_ch.token_type = '0;
        res_ch.ready = 1'b0;
        sp[GEN] = 1;
        sp[CHK] = 1;
        stk[GEN][0] = 8'd0;
        stk[CHK][0] = 8'd0;

        // directed: extremes, each operation, skip, accept, invalid, halted, long chain
        add_write(OP_WR_ACTION, 255, 63, ACT_EMPTY, 255, 31);
        add_write(OP_WR_GOTO, 255, 63, 0, 255, 31);
        add_write(OP_WR_RULE, 255, 63, 3, 255, 31);
        add_write(OP_WR_ACTION, 0, 32, ACT_EMPTY, 0, 0);
        add_token(SKIP_TYPE);
        add_write(OP_WR_ACTION, 0, 0, ACT_SHIFT, 5, 0);
        add_write(OP_WR_ACTION, 5, 2, ACT_REDUCE, 9, 0);
        add_write(OP_WR_RULE, 9, 3, 0, 0, 0);
        add_write(OP_WR_GOTO, 5, 3, 1, 5, 0);
        add_token(1);
        add_token(3);
        add_token(3);
        add_req(noise_req(OP_RESTART));
        add_write(OP_WR_ACTION, 0, 62, ACT_ACCEPT, 0, 0);
        add_token(63);
        add_req(noise_req(OP_RESTART));
        add_token(0);
        add_req(noise_req(OP_RESTART));
        add_token(-64);
        add_req(noise_req(OP_BAD_FIRST));
        add_req(noise_req(OP_BAD_LAST));
        add_req(noise_req(OP_RESTART));
        add_token(-1);
        add_req(noise_req(OP_RESTART));
        add_hold();

        // fill the stack to the brim: each token after the first runs ten empty reductions, then shifts
        add_write(OP_WR_ACTION, 0, 4, ACT_SHIFT, 6, 0);
        add_write(OP_WR_RULE, 20, 10, 0, 0, 0);
        for (k = 6; k < 16; k++)
        begin
            add_write(OP_WR_ACTION, k, 4, ACT_REDUCE, 20, 0);
            add_write(OP_WR_GOTO, k, 10, 1, k + 1, 0);
        end
        add_write(OP_WR_ACTION, 16, 4, ACT_SHIFT, 6, 0);
        for (k = 0; k < 64 && !halt[GEN]; k++)
            add_token(5);
        add_req(noise_req(OP_RESTART));
        add_hold();

        for (k = 0; k < 30; k++)
        begin
            if (k == 15)
                add_hold();
            if (halt[GEN] && $urandom_range(0, 3) != 0)
                add_req(noise_req(OP_RESTART));
            else if ($urandom_range(0, 49) == 0)
                add_req(noise_req(3'($urandom_range(int'(OP_BAD_FIRST), int'(OP_BAD_LAST)))));
            else if ($urandom_range(0, 29) == 0)
                add_req(noise_req(OP_RESTART));
            else
                add_token(rand_type());
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        forever
        begin
            @(posedge clk);
            if (pending.size() == 0 && !item_ch.valid && expected_events.size() == 0)
                break;
        end
        repeat (300) @(posedge clk);
        if (expected_events.size() != 0)
            report($sformatf("%0d results never arrived", expected_events.size()));
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

    // request driver
    int   send_gap = 0;
    req_t cur_req;

    always @(posedge clk or negedge rst_n)
    begin
        int nd, nr, nc;
        req_t nxt;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            quiet = pending.size() < 40;
            if (item_ch.valid && item_ch.ready)
            begin
                parse_step(CHK, cur_req, expected_events, nd, nr, nc);
                if (nd != NEED_NONE)
                    report("stimulus read an unwritten table entry");
            end
            if (item_ch.valid && !item_ch.ready)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                item_ch.valid <= 1'b0;
            end
            else if (pending.size() != 0 && pending[0].hold)
            begin
                item_ch.valid <= 1'b0;
                if (expected_events.size() == 0 && !(item_ch.valid && item_ch.ready))
                    void'(pending.pop_front());
            end
            else if (pending.size() != 0)
            begin
                nxt = pending.pop_front();
                cur_req <= nxt;
                item_ch.valid <= 1'b1;
                item_ch.operation <= nxt.operation;
                item_ch.row <= nxt.row;
                item_ch.column <= nxt.column;
                item_ch.entry_kind <= nxt.entry_kind;
                item_ch.entry_value <= nxt.entry_value;
                item_ch.rule_length <= nxt.rule_length;
                item_ch.token_type <= nxt.token_type;
                if (!quiet && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 7);
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // result monitor
    int stall = 0;

    always @(posedge clk or negedge rst_n)
    begin
        parse_ev_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_events.size() == 0)
                    report($sformatf("unexpected result event %0d", res_ch.event_res));
                else
                begin
                    want = expected_events.pop_front();
                    if (res_ch.event_res !== want.ev)
                        report($sformatf("event %0d, want %s", res_ch.event_res, want.ev.name()));
                    if (res_ch.rule_number !== want.rule_number)
                        report($sformatf("rule_number %0d, want %0d",
                                         res_ch.rule_number, want.rule_number));
                    if (res_ch.new_state !== want.new_state)
                        report($sformatf("new_state %0d, want %0d",
                                         res_ch.new_state, want.new_state));
                    if (res_ch.last !== want.last)
                        report($sformatf("last %0b, want %0b", res_ch.last, want.last));
                end
            end
            if (stall > 0)
            begin
                stall--;
                res_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                stall = $urandom_range(0, 6);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

endmodule
`default_nettype wire
